@@ rtl/u16u8_pkg.sv @@
// Shared types, constants and UTF-8 encoding helpers for the UTF-16 to UTF-8 transcoder.
// No dependencies; every other file of the block imports this package.
package u16u8_pkg;

  localparam int CNT_W   = 16;
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = QPTR_W + 1;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Top six bits of a code unit that mark surrogates.
  localparam logic [5:0] HIGH_SUR_TAG = 6'b110110;
  localparam logic [5:0] LOW_SUR_TAG  = 6'b110111;

  typedef enum logic [1:0] {
    ERR_OK          = 2'd0,
    ERR_LONE_LOW    = 2'd1,
    ERR_HIGH_NO_LOW = 2'd2,
    ERR_PARTIAL     = 2'd3
  } u16u8_err_t;

  // One queue entry: the bytes of a code point, then an optional status item.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      nbytes;
    logic            has_status;
    u16u8_err_t      err;
    logic [15:0]     units;
    logic [15:0]     bw;
  } u16u8_job_t;

  function automatic logic [2:0] enc_len(input logic [20:0] cp);
    logic [2:0] len;
    if (cp < 21'h80) len = 3'd1;
    else if (cp < 21'h800) len = 3'd2;
    else if (cp < 21'h10000) len = 3'd3;
    else len = 3'd4;
    return len;
  endfunction

  // Byte 0 is sent first.
  function automatic logic [3:0][7:0] enc_bytes(input logic [20:0] cp);
    logic [3:0][7:0] b;
    b = '0;
    if (cp < 21'h80) begin
      b[0] = cp[7:0];
    end else if (cp < 21'h800) begin
      b[0] = {3'b110, cp[10:6]};
      b[1] = {2'b10, cp[5:0]};
    end else if (cp < 21'h10000) begin
      b[0] = {4'b1110, cp[15:12]};
      b[1] = {2'b10, cp[11:6]};
      b[2] = {2'b10, cp[5:0]};
    end else begin
      b[0] = {5'b11110, cp[20:18]};
      b[1] = {2'b10, cp[17:12]};
      b[2] = {2'b10, cp[11:6]};
      b[3] = {2'b10, cp[5:0]};
    end
    return b;
  endfunction

endpackage

@@ rtl/u16u8_front.sv @@
// Front end: accepts UTF-16 code units, tracks surrogate and string state, and
// builds one queue entry per unit that causes results. Depends on u16u8_pkg.
module u16u8_front import u16u8_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        accept,
  input  logic [15:0] code_unit,
  input  logic        end_of_string,
  output logic        push,
  output u16u8_job_t  push_job
);

  logic             allow_partial_r;
  logic             have_high_r, have_high_nxt;
  logic [9:0]       pending_r, pending_nxt;
  logic [CNT_W-1:0] unit_cnt_r, unit_cnt_nxt;
  logic [CNT_W-1:0] byte_cnt_r, byte_cnt_nxt;
  logic             dropping_r, dropping_nxt;

  logic             is_low, is_high;
  logic [20:0]      cp;
  logic [2:0]       len;
  logic [CNT_W-1:0] uc_inc;
  logic [CNT_W:0]   bc_sum;
  logic [CNT_W-1:0] bc_inc;
  logic             end_high;
  logic [CNT_W-1:0] end_units;

  assign is_low  = (code_unit[15:10] == LOW_SUR_TAG);
  assign is_high = (code_unit[15:10] == HIGH_SUR_TAG);

  always_comb begin
    if (is_low) cp = 21'h10000 + {1'b0, pending_r, code_unit[9:0]};
    else cp = {5'b0, code_unit};
  end

  always_comb begin
    push          = 1'b0;
    push_job      = '0;
    have_high_nxt = have_high_r;
    pending_nxt   = pending_r;
    unit_cnt_nxt  = unit_cnt_r;
    byte_cnt_nxt  = byte_cnt_r;
    dropping_nxt  = dropping_r;
    len           = enc_len(cp);
    uc_inc        = (unit_cnt_r == CNT_MAX) ? CNT_MAX : unit_cnt_r + 1'b1;
    bc_sum        = '0;
    bc_inc        = byte_cnt_r;
    end_high      = 1'b0;
    end_units     = unit_cnt_r;

    if (dropping_r) begin
      if (code_unit == 16'd0 || end_of_string) begin
        have_high_nxt = 1'b0;
        pending_nxt   = '0;
        unit_cnt_nxt  = '0;
        byte_cnt_nxt  = '0;
        dropping_nxt  = 1'b0;
      end
    end else if (code_unit == 16'd0) begin
      // A zero unit ends the string and is not counted.
      push                = 1'b1;
      push_job.has_status = 1'b1;
      push_job.bw         = byte_cnt_r;
      push_job.units      = unit_cnt_r;
      if (have_high_r) begin
        if (allow_partial_r) begin
          if (unit_cnt_r != '0 && unit_cnt_r != CNT_MAX) push_job.units = unit_cnt_r - 1'b1;
        end else begin
          push_job.err = ERR_PARTIAL;
        end
      end
      have_high_nxt = 1'b0;
      pending_nxt   = '0;
      unit_cnt_nxt  = '0;
      byte_cnt_nxt  = '0;
    end else if ((is_low && !have_high_r) || (!is_low && have_high_r)) begin
      push                = 1'b1;
      push_job.has_status = 1'b1;
      push_job.err        = is_low ? ERR_LONE_LOW : ERR_HIGH_NO_LOW;
      push_job.units      = unit_cnt_r;
      push_job.bw         = byte_cnt_r;
      have_high_nxt       = 1'b0;
      pending_nxt         = '0;
      unit_cnt_nxt        = '0;
      byte_cnt_nxt        = '0;
      dropping_nxt        = !end_of_string;
    end else begin
      if (is_high) begin
        end_high = 1'b1;
        have_high_nxt = 1'b1;
        pending_nxt   = code_unit[9:0];
      end else begin
        have_high_nxt   = 1'b0;
        pending_nxt     = '0;
        push_job.bytes  = enc_bytes(cp);
        push_job.nbytes = len;
        bc_sum          = {1'b0, byte_cnt_r} + {{(CNT_W - 2){1'b0}}, len};
      end
      if (!is_high) bc_inc = bc_sum[CNT_W] ? CNT_MAX : bc_sum[CNT_W-1:0];
      unit_cnt_nxt = uc_inc;
      byte_cnt_nxt = bc_inc;
      push         = !is_high || end_of_string;
      if (end_of_string) begin
        end_units = uc_inc;
        if (end_high && allow_partial_r && uc_inc != '0 && uc_inc != CNT_MAX)
          end_units = uc_inc - 1'b1;
        push_job.has_status = 1'b1;
        push_job.err        = (end_high && !allow_partial_r) ? ERR_PARTIAL : ERR_OK;
        push_job.units      = end_units;
        push_job.bw         = bc_inc;
        have_high_nxt       = 1'b0;
        pending_nxt         = '0;
        unit_cnt_nxt        = '0;
        byte_cnt_nxt        = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      allow_partial_r <= 1'b0;
      have_high_r     <= 1'b0;
      pending_r       <= '0;
      unit_cnt_r      <= '0;
      byte_cnt_r      <= '0;
      dropping_r      <= 1'b0;
    end else begin
      if (cfg_wr_en) allow_partial_r <= cfg_wr_data;
      if (accept) begin
        have_high_r <= have_high_nxt;
        pending_r   <= pending_nxt;
        unit_cnt_r  <= unit_cnt_nxt;
        byte_cnt_r  <= byte_cnt_nxt;
        dropping_r  <= dropping_nxt;
      end
    end
  end

endmodule

@@ rtl/u16u8_queue.sv @@
// Short queue of encoded entries between the front and back ends.
// Depends on u16u8_pkg for the entry type and depth.
module u16u8_queue import u16u8_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  u16u8_job_t push_job,
  output logic       full,
  input  logic       pop,
  output logic       head_valid,
  output u16u8_job_t head
);

  u16u8_job_t        mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  assign full       = (cnt_r == QCNT_W'(QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

@@ rtl/u16u8_back.sv @@
// Back end: walks the head queue entry one result at a time into the output
// register of the result stream. Depends on u16u8_pkg.
module u16u8_back import u16u8_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        head_valid,
  input  u16u8_job_t  head,
  output logic        pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,
  output logic [1:0]  out_tuser,
  output logic        out_tlast
);

  logic [2:0]  idx_r;
  logic        out_valid_r;
  logic [47:0] out_data_r;
  logic [1:0]  out_user_r;
  logic        out_last_r;

  logic        load;
  logic        elem_is_byte;
  logic        last_elem;
  logic [47:0] elem_data;
  logic [1:0]  elem_user;

  assign load         = head_valid && (!out_valid_r || out_tready);
  assign elem_is_byte = (idx_r < head.nbytes);
  assign last_elem    = elem_is_byte ? ((idx_r == head.nbytes - 3'd1) && !head.has_status)
                                     : 1'b1;
  assign pop          = load && last_elem;

  always_comb begin
    if (elem_is_byte) begin
      elem_data = {40'd0, head.bytes[idx_r[1:0]]};
      elem_user = 2'b01;
    end else begin
      elem_data = {6'd0, head.bw, head.units, head.err, 8'd0};
      elem_user = 2'b10;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= elem_data;
      out_user_r <= elem_user;
      out_last_r <= last_elem;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        idx_r       <= last_elem ? 3'd0 : idx_r + 3'd1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule

@@ rtl/utf16_to_utf8_transcoder_core.sv @@
// Top level of the UTF-16 to UTF-8 transcoder: front end, entry queue, back end.
// Depends on u16u8_pkg, u16u8_front, u16u8_queue and u16u8_back.
//
// One UTF-16 code unit enters per transaction and leaves as zero to four UTF-8
// bytes, followed at string end (zero unit or in_tlast) by one status
// transaction carrying the error code, units read and bytes written. The front
// end takes a unit every cycle while its four-entry queue has room; the back
// end sends one result per cycle while out_tready allows. A unit has one result
// for ASCII, up to four for a surrogate pair, plus one for a status. The
// single-result output register sets the sustained rate. Surrogate errors
// report at once and the rest of the string is dropped silently. Write
// allow_partial only while idle.
module utf16_to_utf8_transcoder_core import u16u8_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,   // allow_partial
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,      // [15:0] code_unit
  input  logic        in_tlast,      // end_of_string
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,     // [7:0] out_byte, [9:8] error_code,
                                     // [25:10] units_read, [41:26] bytes_written
  output logic [1:0]  out_tuser,     // [0] byte_valid, [1] string_done
  output logic        out_tlast      // last_of_run
);

  logic       accept;
  logic       push;
  logic       full;
  logic       pop;
  logic       head_valid;
  u16u8_job_t push_job;
  u16u8_job_t head;

  assign in_tready = !full;
  assign accept    = in_tvalid && in_tready;

  u16u8_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .accept        (accept),
    .code_unit     (in_tdata),
    .end_of_string (in_tlast),
    .push          (push),
    .push_job      (push_job)
  );

  u16u8_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push && accept),
    .push_job   (push_job),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  u16u8_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
